>>> sv/bsm_pkg.sv
// shared types and constants of the byte signature matcher
package bsm_pkg;

  localparam int MAX_SIG_BYTES_DEF = 'h40;
  localparam int OFFSET_BITS_DEF   = 32;
  localparam int SIG_LEN_W         = 7;
  localparam int COUNT_W           = 32;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] sig_index;
    logic [7:0] byte_value;
  } src_item_t;

  typedef struct packed {
    logic         kind;
    logic [31:0]  match_offset;
    logic [31:0]  match_count;
  } res_item_t;

  typedef struct packed {
    logic data_en;
    logic sig_shift;
    logic load_en;
  } cell_ctl_t;

endpackage

>>> sv/bsm_cell.sv
// one matcher cell: a window byte, an aligned signature byte and its compare bit
module bsm_cell #(
  parameter int CELL_IDX = 0,
  parameter int LEN_W    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  bsm_pkg::cell_ctl_t ctl,
  input  logic [LEN_W-1:0]   len_eff,
  input  logic [LEN_W-1:0]   load_tgt,
  input  logic [7:0]         load_byte,
  input  logic [7:0]         win_in,
  output logic [7:0]         win_out,
  input  logic [7:0]         sig_in,
  output logic [7:0]         sig_out,
  output logic               hit
);

  logic [7:0] win;
  logic [7:0] asig;
  logic       in_use;
  logic       load_sel;

  assign in_use   = LEN_W'(CELL_IDX) < len_eff;
  assign load_sel = ctl.load_en && (load_tgt == LEN_W'(CELL_IDX));
  assign win_out  = win;
  assign sig_out  = asig;

  always_ff @(posedge clk) begin
    if (rst) begin
      asig <= '0;
    end else if (ctl.sig_shift) begin
      asig <= sig_in;
    end else if (load_sel) begin
      asig <= load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.data_en) begin
      win <= win_in;
      hit <= !in_use || (win_in == asig);
    end
  end

endmodule

>>> sv/bsm_sig_store.sv
// signature store with the sweep that realigns the cell signatures
module bsm_sig_store #(
  parameter int MAX_SIG_BYTES = bsm_pkg::MAX_SIG_BYTES_DEF,
  parameter int LEN_W         = 7,
  parameter int IDX_W         = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_byte,
  input  logic             start,
  input  logic [LEN_W-1:0] len_eff,
  output logic             shift_en,
  output logic [7:0]       shift_byte,
  output logic             busy
);

  typedef enum logic {RB_IDLE, RB_READ} rb_state_t;

  rb_state_t          state;
  logic [IDX_W-1:0]   rd_addr;
  logic               last;
  logic [7:0]         mem [MAX_SIG_BYTES];
  logic [MAX_SIG_BYTES-1:0] vld;

  assign last = ((LEN_W+1)'(rd_addr) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_eff);
  assign busy = (state == RB_READ) || shift_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= RB_IDLE;
      shift_en <= 1'b0;
      rd_addr  <= '0;
    end else begin
      shift_en <= 1'b0;
      case (state)
        RB_IDLE: begin
          if (start) begin
            rd_addr <= '0;
            state   <= RB_READ;
          end
        end
        RB_READ: begin
          shift_en <= 1'b1;
          if (last) begin
            state <= RB_IDLE;
          end else begin
            rd_addr <= rd_addr + IDX_W'(1);
          end
        end
        default: state <= RB_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    shift_byte <= vld[rd_addr] ? mem[rd_addr] : 8'h00;
  end

endmodule

>>> sv/byte_signature_matcher_core.sv
// top level of the byte signature matcher
//
//   channel   signals                          item
//   src       src_valid src_ready src_item     load, data or end command
//   res       res_valid res_ready res_item     match or end-of-stream total
//   cfg       cfg_valid cfg_ready cfg_data     signature length
//
// one item per cycle while src_ready is high; an item passes the window compare
// (one cell per signature byte), its hits and-reduced into the result register
// a length write realigns the cells from the signature store; while it runs,
// src_ready and cfg_ready are low
// reset clears the signature, position, count and length (to one)
// a stalled result holds one more item in the compare stage, then src_ready drops
module byte_signature_matcher_core #(
  parameter int MAX_SIG_BYTES = bsm_pkg::MAX_SIG_BYTES_DEF,
  parameter int OFFSET_BITS   = bsm_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_ready,
  input  bsm_pkg::src_item_t              src_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output bsm_pkg::res_item_t              res_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsm_pkg::SIG_LEN_W-1:0]   cfg_data
);

  localparam int LEN_W = $clog2(MAX_SIG_BYTES + 1);
  localparam int IDX_W = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES) : 1;
  localparam int CW    = bsm_pkg::COUNT_W;

  logic [bsm_pkg::SIG_LEN_W-1:0] sig_len;
  logic [LEN_W-1:0]              len_eff;
  logic                          busy;
  logic                          src_take;
  logic                          take_load;
  logic                          take_data;
  logic                          take_end;
  logic                          idx_ok;
  logic                          ld_cell;
  logic [LEN_W-1:0]              ld_tgt;
  logic                          cfg_take;
  logic                          sh_en;
  logic [7:0]                    sh_byte;
  bsm_pkg::cell_ctl_t            ctl;
  logic [7:0]                    win_chain [MAX_SIG_BYTES+1];
  logic [7:0]                    sig_chain [MAX_SIG_BYTES+1];
  logic [MAX_SIG_BYTES-1:0]      hits;

  logic [OFFSET_BITS-1:0]        pos;
  logic [OFFSET_BITS-1:0]        pos_next;
  logic [OFFSET_BITS-1:0]        diff;
  logic [OFFSET_BITS+31:0]       diff_ext;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_inc;

  logic                          s1_valid;
  logic                          s1_end;
  logic                          s1_short;
  logic [31:0]                   s1_offset;
  logic                          advance;
  logic                          s1_take;
  logic                          is_match;

  always_comb begin
    if (sig_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(sig_len) > 32'(MAX_SIG_BYTES)) begin
      len_eff = LEN_W'(MAX_SIG_BYTES);
    end else begin
      len_eff = LEN_W'(sig_len);
    end
  end

  assign advance   = !res_valid || res_ready;
  assign src_ready = !busy && (!s1_valid || advance);
  assign cfg_ready = !busy;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign src_take  = src_valid && src_ready;
  assign take_load = src_take && (src_item.cmd == bsm_pkg::CMD_LOAD);
  assign take_data = src_take && (src_item.cmd == bsm_pkg::CMD_DATA);
  assign take_end  = src_take && (src_item.cmd == bsm_pkg::CMD_END);

  assign idx_ok  = 32'(src_item.sig_index) < 32'(MAX_SIG_BYTES);
  assign ld_cell = idx_ok && (32'(src_item.sig_index) < 32'(len_eff));
  assign ld_tgt  = LEN_W'(32'(len_eff) - 32'd1 - 32'(src_item.sig_index));

  assign ctl.data_en   = take_data;
  assign ctl.sig_shift = sh_en;
  assign ctl.load_en   = take_load && ld_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_len <= bsm_pkg::SIG_LEN_W'(1);
    end else if (cfg_take) begin
      sig_len <= cfg_data;
    end
  end

  bsm_sig_store #(
    .MAX_SIG_BYTES (MAX_SIG_BYTES),
    .LEN_W         (LEN_W),
    .IDX_W         (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (take_load && idx_ok),
    .wr_addr    (IDX_W'(src_item.sig_index)),
    .wr_byte    (src_item.byte_value),
    .start      (cfg_take),
    .len_eff    (len_eff),
    .shift_en   (sh_en),
    .shift_byte (sh_byte),
    .busy       (busy)
  );

  assign win_chain[0] = src_item.byte_value;
  assign sig_chain[0] = sh_byte;

  for (genvar i = 0; i < MAX_SIG_BYTES; i++) begin : g_cell
    bsm_cell #(
      .CELL_IDX (i),
      .LEN_W    (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .len_eff   (len_eff),
      .load_tgt  (ld_tgt),
      .load_byte (src_item.byte_value),
      .win_in    (win_chain[i]),
      .win_out   (win_chain[i+1]),
      .sig_in    (sig_chain[i]),
      .sig_out   (sig_chain[i+1]),
      .hit       (hits[i])
    );
  end

  assign pos_next  = (pos == '1) ? pos : pos + OFFSET_BITS'(1);
  assign diff      = pos_next - OFFSET_BITS'(len_eff);
  assign diff_ext  = {32'b0, diff};
  assign count_inc = (count == '1) ? count : count + CW'(1);
  assign s1_take   = advance && s1_valid;
  assign is_match  = !s1_end && !s1_short && (&hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (take_data) begin
        pos <= pos_next;
      end else if (take_end) begin
        pos <= '0;
      end
      if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (take_data || take_end) begin
        s1_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_data || take_end) begin
      s1_end    <= take_end;
      s1_short  <= pos_next < OFFSET_BITS'(len_eff);
      s1_offset <= diff_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid && (s1_end || is_match);
      if (s1_valid && s1_end) begin
        count <= '0;
      end else if (s1_valid && is_match) begin
        count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1_end) begin
        res_item.kind         <= bsm_pkg::KIND_TOTAL;
        res_item.match_offset <= '0;
        res_item.match_count  <= 32'(count);
      end else begin
        res_item.kind         <= bsm_pkg::KIND_MATCH;
        res_item.match_offset <= s1_offset;
        res_item.match_count  <= 32'(count_inc);
      end
    end
  end

endmodule

>>> sv/bsm_checker.sv
// port-level checks of the byte signature matcher, bound to the top level
module bsm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          src_valid,
  input logic                          src_ready,
  input bsm_pkg::src_item_t            src_item,
  input logic                          res_valid,
  input logic                          res_ready,
  input bsm_pkg::res_item_t            res_item,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [bsm_pkg::SIG_LEN_W-1:0] cfg_data
);

  logic [1:0] unused_src;
  assign unused_src = src_item.cmd ^ {src_valid, cfg_data[0]};

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_total_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == bsm_pkg::KIND_TOTAL) |-> res_item.match_offset == 32'd0)
    else $error("total carries an offset");

  a_match_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == bsm_pkg::KIND_MATCH) |-> res_item.match_count != 32'd0)
    else $error("match with zero count");

  a_cfg_realign: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !src_ready && !cfg_ready)
    else $error("item taken during realignment");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    !cfg_ready |-> !src_ready)
    else $error("item taken while store busy");

endmodule

bind byte_signature_matcher_core bsm_checker u_bsm_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .src_item  (src_item),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

>>> bench/tb_byte_signature_matcher_core.sv
// self-checking testbench of byte_signature_matcher_core: directed and random streams
`timescale 1ns / 100ps

module tb_byte_signature_matcher_core;

  localparam int MAX_SIG = bsm_pkg::MAX_SIG_BYTES_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  bsm_pkg::src_item_t src_item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  bsm_pkg::res_item_t res_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bsm_pkg::SIG_LEN_W-1:0] cfg_data = '0;

  // predicted state of the matcher
  logic [7:0] sig_mem [MAX_SIG] = '{default: 8'h00};
  logic [7:0] window [MAX_SIG] = '{default: 8'h00};
  logic [31:0] stream_pos = '0;
  logic [31:0] match_total = '0;
  logic [bsm_pkg::SIG_LEN_W-1:0] sig_len = 7'd1;

  bsm_pkg::res_item_t expected_results [$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  byte_signature_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_byte_signature_matcher_core NOT OK");
    $finish;
  end

  function automatic int eff_length(input logic [bsm_pkg::SIG_LEN_W-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_SIG) return MAX_SIG;
    return int'(code);
  endfunction

  function automatic bit predict_match(input bsm_pkg::src_item_t it,
                                       output bsm_pkg::res_item_t r);
    int eff;
    bit hit;
    r = '0;
    case (it.cmd)
      bsm_pkg::CMD_LOAD: begin
        sig_mem[it.sig_index] = it.byte_value;
        return 1'b0;
      end
      bsm_pkg::CMD_DATA: begin
        eff = eff_length(sig_len);
        for (int i = MAX_SIG - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = it.byte_value;
        if (stream_pos != 32'hFFFF_FFFF) stream_pos++;
        if (stream_pos < eff) return 1'b0;
        hit = 1'b1;
        for (int i = 0; i < eff; i++) begin
          if (window[i] != sig_mem[eff-1-i]) hit = 1'b0;
        end
        if (!hit) return 1'b0;
        if (match_total != 32'hFFFF_FFFF) match_total++;
        r.kind = bsm_pkg::KIND_MATCH;
        r.match_offset = stream_pos - 32'(eff);
        r.match_count = match_total;
        return 1'b1;
      end
      bsm_pkg::CMD_END: begin
        r.kind = bsm_pkg::KIND_TOTAL;
        r.match_offset = '0;
        r.match_count = match_total;
        stream_pos = '0;
        match_total = '0;
        for (int i = 0; i < MAX_SIG; i++) window[i] = 8'h00;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // result checker
  always @(posedge clk) begin
    bsm_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (res_item.kind !== want.kind)
          report_mismatch($sformatf("kind %0b, expected %0b", res_item.kind, want.kind));
        if (res_item.match_offset !== want.match_offset)
          report_mismatch($sformatf("match_offset %0d, expected %0d",
                                    res_item.match_offset, want.match_offset));
        if (res_item.match_count !== want.match_count)
          report_mismatch($sformatf("match_count %0d, expected %0d",
                                    res_item.match_count, want.match_count));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    res_ready <= no_idle || ($urandom_range(99) >= 30);
  end

  task automatic send_item(input bsm_pkg::src_item_t it);
    bsm_pkg::res_item_t r;
    while (!no_idle && $urandom_range(99) < 30) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_item <= it;
    do @(posedge clk); while (!src_ready);
    if (predict_match(it, r)) expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] c, input logic [5:0] idx, input logic [7:0] v);
    send_item('{cmd: c, sig_index: idx, byte_value: v});
  endtask

  task automatic send_data(input logic [7:0] v);
    send_cmd(bsm_pkg::CMD_DATA, 6'($urandom_range(63)), v);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [bsm_pkg::SIG_LEN_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sig_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // zero signature and length one after reset
  task automatic test_reset_defaults();
    send_data(8'h00);
    send_data(8'hFF);
    send_cmd(bsm_pkg::CMD_END, 6'h3F, 8'hFF);
  endtask

  // length zero acts as one; unused command gives nothing
  task automatic test_length_zero();
    write_length(7'd0);
    send_cmd(bsm_pkg::CMD_LOAD, 6'd0, 8'hFF);
    send_data(8'hFF);
    send_data(8'h00);
    send_cmd(CMD_UNUSED, 6'h2A, 8'h5A);
    send_data(8'hFF);
    send_cmd(bsm_pkg::CMD_END, 6'd0, 8'h00);
  endtask

  // overlapping matches and short stream
  task automatic test_overlapping();
    write_length(7'd2);
    send_cmd(bsm_pkg::CMD_LOAD, 6'd0, 8'hAA);
    send_cmd(bsm_pkg::CMD_LOAD, 6'd1, 8'hAA);
    send_data(8'hAA);
    send_data(8'hAA);
    send_data(8'hAA);
    send_cmd(bsm_pkg::CMD_END, 6'd0, 8'h00);
  endtask

  // top index, oversized length, signature rewritten mid-stream
  task automatic test_index_and_change();
    write_length(7'd127);
    send_cmd(bsm_pkg::CMD_LOAD, 6'd63, 8'h3C);
    send_data(8'h3C);
    send_cmd(bsm_pkg::CMD_END, 6'd0, 8'h00);
    write_length(7'd1);
    send_data(8'h12);
    send_cmd(bsm_pkg::CMD_LOAD, 6'd0, 8'h12);
    send_data(8'h12);
    send_cmd(bsm_pkg::CMD_END, 6'd0, 8'h00);
  endtask

  task automatic test_random_phases();
    logic [7:0] pat [MAX_SIG];
    logic [7:0] sym_a, sym_b, v;
    logic [bsm_pkg::SIG_LEN_W-1:0] len_code;
    logic [bsm_pkg::SIG_LEN_W-1:0] extremes [5];
    int eff, segs, pick, n, k, idx, phase, stop_at;
    extremes = '{7'd0, 7'd127, 7'd65, 7'd64, 7'd63};
    phase = 0;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) len_code = extremes[$urandom_range(4)];
      else if (pick < 16) len_code = 7'($urandom_range(64, 7));
      else len_code = 7'($urandom_range(6, 1));
      no_idle = (phase >= 6 && phase < 14);
      write_length(len_code);
      eff = eff_length(len_code);
      sym_a = 8'($urandom_range(255));
      sym_b = 8'($urandom_range(255));
      for (k = 0; k < eff; k++) begin
        pat[k] = $urandom_range(1) ? sym_a : sym_b;
        send_cmd(bsm_pkg::CMD_LOAD, 6'(k), pat[k]);
      end
      segs = (eff > 8) ? $urandom_range(5, 2) : $urandom_range(12, 3);
      for (n = 0; n < segs; n++) begin
        if ((phase == 2 && n == segs / 2) || $urandom_range(39) == 0) wait_drained();
        pick = $urandom_range(99);
        if (pick < 50) begin
          for (k = 0; k < eff; k++) send_data(pat[k]);
        end else if (pick < 65) begin
          idx = $urandom_range(eff - 1, 0);
          for (k = 0; k < idx; k++) send_data(pat[k]);
        end else if (pick < 85) begin
          repeat ($urandom_range(4, 1)) send_data($urandom_range(1) ? sym_a : sym_b);
        end else if (pick < 90) begin
          send_data(8'($urandom_range(255)));
        end else if (pick < 94) begin
          send_cmd(CMD_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)));
        end else if (pick < 98) begin
          idx = $urandom_range(63);
          v = $urandom_range(3) ? ($urandom_range(1) ? sym_a : sym_b) : 8'($urandom_range(255));
          if (idx < eff) pat[idx] = v;
          send_cmd(bsm_pkg::CMD_LOAD, 6'(idx), v);
        end else begin
          send_cmd(bsm_pkg::CMD_END, 6'($urandom_range(63)), 8'($urandom_range(255)));
        end
      end
      send_cmd(bsm_pkg::CMD_END, 6'($urandom_range(63)), 8'($urandom_range(255)));
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_length_zero();
    test_overlapping();
    test_index_and_change();
    test_random_phases();
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_byte_signature_matcher_core OK");
    end else begin
      $display("tb_byte_signature_matcher_core NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bsm_pkg.sv
sv/bsm_cell.sv
sv/bsm_sig_store.sv
sv/byte_signature_matcher_core.sv
sv/bsm_checker.sv
bench/tb_byte_signature_matcher_core.sv
